// File: design/twbo_pkg.sv
// Shared types, constants and arithmetic helpers of the two-wheel base odometry block.
package twbo_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STEPS  = 16;
   localparam int CFG_FRAC      = 16;
   localparam int WIDE_W        = 68;
   localparam int MUL_B_W       = 33;
   localparam int MUL_CNT_W     = 6;
   localparam int MOD_W         = 64;
   localparam int MOD_CNT_W     = 5;
   localparam int ANG_W         = 34;
   localparam int CORDIC_CNT_W  = 5;
   localparam int ENC_MOD_SHIFT  = 32 - FRAC_BITS;
   localparam int HEAD_MOD_SHIFT = 29 - FRAC_BITS;
   localparam int HEAD_UP_SHIFT  = 30 - FRAC_BITS;

   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic signed [MOD_W-1:0]   mod_type;
   typedef logic signed [ANG_W-1:0]   ang_type;
   typedef logic signed [31:0]        word_type;
   typedef logic signed [MUL_B_W-1:0] mul_b_type;

   localparam mod_type PI_Q32      = 64'sd13493037705;
   localparam mod_type PI_FX       =
      (PI_Q32 + (mod_type'(1) <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
   localparam mod_type TWO_PI_FX   =
      ((PI_Q32 <<< 1) + (mod_type'(1) <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
   localparam mod_type ENC_MOD_BASE  = TWO_PI_FX <<< ENC_MOD_SHIFT;
   localparam mod_type PI_Q30        = 64'sd3373259426;
   localparam mod_type TWO_PI_Q30    = 64'sd6746518852;
   localparam mod_type HEAD_MOD_BASE = TWO_PI_Q30 <<< HEAD_MOD_SHIFT;
   localparam ang_type PI_Q30_ANG    = 34'sd3373259426;
   localparam ang_type HALF_PI_Q30   = 34'sd1686629713;
   localparam ang_type CORDIC_GAIN   = 34'sd652032874;

   localparam wide_type WORD_MAX = (wide_type'(1) <<< 31) - wide_type'(1);
   localparam wide_type WORD_MIN = -(wide_type'(1) <<< 31);

   localparam logic [2:0] REG_SAMPLE_PERIOD     = 3'd0;
   localparam logic [2:0] REG_SAMPLE_RATE_HZ    = 3'd1;
   localparam logic [2:0] REG_FILTER_ALPHA      = 3'd2;
   localparam logic [2:0] REG_WHEEL_RADIUS      = 3'd3;
   localparam logic [2:0] REG_RADIUS_OVER_TRACK = 3'd4;
   localparam logic [2:0] REG_INV_GEAR_RATIO    = 3'd5;

   typedef struct packed {
      logic start;
      logic accumulate;
   } mul_ctrl_type;

   typedef struct packed {
      logic signed [31:0] left_enc_angle;
      logic signed [31:0] right_enc_angle;
      logic signed [31:0] body_pitch;
      logic signed [31:0] body_pitch_rate;
      logic               measuring;
      logic               timed_out;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] left_wheel_angle;
      logic signed [31:0] right_wheel_angle;
      logic signed [31:0] mean_wheel_angle;
      logic signed [31:0] left_wheel_speed;
      logic signed [31:0] right_wheel_speed;
      logic signed [31:0] mean_wheel_speed;
      logic signed [31:0] heading;
      logic signed [31:0] linear_speed;
      logic signed [31:0] turn_rate;
      logic signed [31:0] position_x;
      logic signed [31:0] position_y;
      logic signed [31:0] travelled;
   } rsp_payload_type;

   function automatic wide_type round_shift(input wide_type v, input int s);
      return (v + (wide_type'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic word_type sat_word(input wide_type v);
      word_type r;
      if (v > WORD_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < WORD_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic ang_type atan_q30(input logic [CORDIC_CNT_W-1:0] idx);
      ang_type r;
      case (idx)
         5'd0:  r = 34'sh3243F6A8;
         5'd1:  r = 34'sh1DAC6705;
         5'd2:  r = 34'sh0FADBAFC;
         5'd3:  r = 34'sh07F56EA6;
         5'd4:  r = 34'sh03FEAB76;
         5'd5:  r = 34'sh01FFD55B;
         5'd6:  r = 34'sh00FFFAAA;
         5'd7:  r = 34'sh007FFF55;
         5'd8:  r = 34'sh003FFFEA;
         5'd9:  r = 34'sh001FFFFD;
         5'd10: r = 34'sh000FFFFF;
         5'd11: r = 34'sh0007FFFF;
         5'd12: r = 34'sh0003FFFF;
         5'd13: r = 34'sh0001FFFF;
         5'd14: r = 34'sh0000FFFF;
         5'd15: r = 34'sh00007FFF;
         5'd16: r = 34'sh00003FFF;
         5'd17: r = 34'sh00001FFF;
         5'd18: r = 34'sh00000FFF;
         5'd19: r = 34'sh000007FF;
         5'd20: r = 34'sh000003FF;
         5'd21: r = 34'sh000001FF;
         5'd22: r = 34'sh000000FF;
         5'd23: r = 34'sh0000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: design/twbo_stream_if.sv
// Valid/ready stream channel carrying one payload.
interface twbo_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: design/twbo_mul.sv
// Bit-serial signed multiplier, one bit of the second operand per cycle, with accumulate.
module twbo_mul import twbo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mul_ctrl_type ctrl,
   input  wide_type     a,
   input  mul_b_type    b,
   output wide_type     product,
   output logic         busy
);

   wide_type               a_ff, a_in;
   mul_b_type              b_ff, b_in;
   wide_type               acc_ff, acc_in;
   logic [MUL_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   wide_type               partial;
   logic                   last;

   assign partial = b_ff[0] ? a_ff : '0;
   assign last    = (cnt_ff == MUL_CNT_W'(MUL_B_W - 1));

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctrl.start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = ctrl.accumulate ? acc_ff : '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = last ? acc_ff - partial : acc_ff + partial;
         a_in   = a_ff <<< 1;
         b_in   = b_ff >>> 1;
         cnt_in = cnt_ff + MUL_CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff;
   assign busy    = busy_ff;

endmodule

// File: design/twbo_cordic.sv
// Iterative rotation-mode CORDIC giving the cosine and sine of a Q4.30 angle.
module twbo_cordic import twbo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  ang_type angle,
   output ang_type cos_out,
   output ang_type sin_out,
   output logic    busy
);

   ang_type                 x_ff, x_in;
   ang_type                 y_ff, y_in;
   ang_type                 z_ff, z_in;
   logic                    neg_ff, neg_in;
   logic [CORDIC_CNT_W-1:0] step_ff, step_in;
   logic                    busy_ff, busy_in;
   ang_type                 x_sh, y_sh, step_atan;

   assign x_sh      = x_ff >>> step_ff;
   assign y_sh      = y_ff >>> step_ff;
   assign step_atan = atan_q30(step_ff);

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         step_in = '0;
         busy_in = 1'b1;
         if (angle > HALF_PI_Q30) begin
            z_in   = angle - PI_Q30_ANG;
            neg_in = 1'b1;
         end else if (angle < -HALF_PI_Q30) begin
            z_in   = angle + PI_Q30_ANG;
            neg_in = 1'b1;
         end else begin
            z_in   = angle;
            neg_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - step_atan;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + step_atan;
         end
         step_in = step_ff + CORDIC_CNT_W'(1);
         if (step_ff == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;
   assign busy    = busy_ff;

endmodule

// File: design/two_wheel_base_odometry.sv
// Top level of the two-wheel base odometry block.
// A measuring request runs from its acceptance until its result stands in the output
// register: eighteen products pass one at a time through a bit-serial multiplier that
// loads each, steps through the 33 bits of its second operand and then collects it, the
// two encoder wraps and the heading reduction run in a restoring remainder unit of one
// step per cycle, the CORDIC runs, and the means and the hand-over follow. A request
// with timed_out or without measuring goes straight to the hand-over, which moves its
// result to the output register once that register is free. A new request can be taken
// as soon as the previous result is in the output register, even if it is still untaken.
module two_wheel_base_odometry import twbo_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   twbo_stream_if.sink         req_ch,
   twbo_stream_if.source       rsp_ch,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int RES_COUNT      = 12;
   localparam int RES_LEFT_ANG   = 0;
   localparam int RES_RIGHT_ANG  = 1;
   localparam int RES_MEAN_ANG   = 2;
   localparam int RES_LEFT_SPD   = 3;
   localparam int RES_RIGHT_SPD  = 4;
   localparam int RES_MEAN_SPD   = 5;
   localparam int RES_HEADING    = 6;
   localparam int RES_LINEAR     = 7;
   localparam int RES_TURN       = 8;
   localparam int RES_POS_X      = 9;
   localparam int RES_POS_Y      = 10;
   localparam int RES_TRAVELLED  = 11;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_MOD_L   = 5'd1;
   localparam logic [4:0] S_MOD_R   = 5'd2;
   localparam logic [4:0] S_ANG_L   = 5'd3;
   localparam logic [4:0] S_ANG_R   = 5'd4;
   localparam logic [4:0] S_RATE_L  = 5'd5;
   localparam logic [4:0] S_RAW_L   = 5'd6;
   localparam logic [4:0] S_RATE_R  = 5'd7;
   localparam logic [4:0] S_RAW_R   = 5'd8;
   localparam logic [4:0] S_FILT_L0 = 5'd9;
   localparam logic [4:0] S_FILT_L1 = 5'd10;
   localparam logic [4:0] S_FILT_R0 = 5'd11;
   localparam logic [4:0] S_FILT_R1 = 5'd12;
   localparam logic [4:0] S_HEAD    = 5'd13;
   localparam logic [4:0] S_LIN     = 5'd14;
   localparam logic [4:0] S_TURN    = 5'd15;
   localparam logic [4:0] S_HMOD    = 5'd16;
   localparam logic [4:0] S_CORDIC  = 5'd17;
   localparam logic [4:0] S_XC      = 5'd18;
   localparam logic [4:0] S_XP      = 5'd19;
   localparam logic [4:0] S_YC      = 5'd20;
   localparam logic [4:0] S_YP      = 5'd21;
   localparam logic [4:0] S_TRAV    = 5'd22;
   localparam logic [4:0] S_MEAN    = 5'd23;
   localparam logic [4:0] S_DONE    = 5'd24;

   logic [4:0]             state_ff, state_in;
   logic                   go_ff, go_in;
   word_type               enc_l_ff, enc_l_in, enc_r_ff, enc_r_in;
   word_type               pitch_ff, pitch_in, prate_ff, prate_in;
   word_type               unw_l_ff, unw_l_in, unw_r_ff, unw_r_in;
   word_type               dl_ff, dl_in, dr_ff, dr_in;
   word_type               raw_l_ff, raw_l_in, raw_r_ff, raw_r_in;
   wide_type               t_ff, t_in;
   ang_type                z_ff, z_in;
   word_type               held_ff [RES_COUNT];
   word_type               held_in [RES_COUNT];
   rsp_payload_type        out_ff, out_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mod_type                mod_r_ff, mod_r_in, mod_d_ff, mod_d_in;
   logic [MOD_CNT_W-1:0]   mod_cnt_ff, mod_cnt_in;

   logic [15:0]            period_ff, rate_ff, radius_ff, igr_ff;
   logic [16:0]            alpha_ff, rot_ff;
   logic [16:0]            alpha_eff, alpha_rest;

   logic                   accept, csr_write, mul_done;
   mul_ctrl_type           mul_ctrl;
   wide_type               mul_a, mul_product;
   mul_b_type              mul_b;
   logic                   mul_busy;
   logic                   cordic_start, cordic_busy;
   ang_type                cordic_cos, cordic_sin;
   mod_type                mod_next_r, enc_delta, head_z;
   wide_type               prod_r16, prod_r17, prod_r30;
   word_type               delta_word;

   assign accept    = req_ch.valid && req_ch.ready;
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = out_ff;

   assign alpha_eff  = (alpha_ff > 17'd65536) ? 17'd65536 : alpha_ff;
   assign alpha_rest = 17'd65536 - alpha_eff;

   assign mod_next_r = (mod_r_ff >= mod_d_ff) ? mod_r_ff - mod_d_ff : mod_r_ff;
   assign enc_delta  = PI_FX - mod_next_r;
   assign delta_word = enc_delta[31:0];
   assign head_z     = mod_next_r - PI_Q30;

   assign prod_r16 = round_shift(mul_product, CFG_FRAC);
   assign prod_r17 = round_shift(mul_product, CFG_FRAC + 1);
   assign prod_r30 = round_shift(mul_product, 30);
   assign mul_done = go_ff && !mul_busy;

   twbo_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mul_ctrl),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_product),
      .busy    (mul_busy)
   );

   twbo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (z_ff),
      .cos_out (cordic_cos),
      .sin_out (cordic_sin),
      .busy    (cordic_busy)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_ctrl.accumulate = 1'b0;
      unique case (state_ff)
         S_ANG_L: begin
            mul_a = wide_type'(unw_l_ff);
            mul_b = mul_b_type'(igr_ff);
         end
         S_ANG_R: begin
            mul_a = wide_type'(unw_r_ff);
            mul_b = mul_b_type'(igr_ff);
         end
         S_RATE_L: begin
            mul_a = wide_type'(dl_ff);
            mul_b = mul_b_type'(rate_ff);
         end
         S_RATE_R: begin
            mul_a = wide_type'(dr_ff);
            mul_b = mul_b_type'(rate_ff);
         end
         S_RAW_L, S_RAW_R: begin
            mul_a = t_ff;
            mul_b = mul_b_type'(igr_ff);
         end
         S_FILT_L0: begin
            mul_a = wide_type'(held_ff[RES_LEFT_SPD]);
            mul_b = mul_b_type'(alpha_rest);
         end
         S_FILT_L1: begin
            mul_a = wide_type'(raw_l_ff);
            mul_b = mul_b_type'(alpha_eff);
            mul_ctrl.accumulate = 1'b1;
         end
         S_FILT_R0: begin
            mul_a = wide_type'(held_ff[RES_RIGHT_SPD]);
            mul_b = mul_b_type'(alpha_rest);
         end
         S_FILT_R1: begin
            mul_a = wide_type'(raw_r_ff);
            mul_b = mul_b_type'(alpha_eff);
            mul_ctrl.accumulate = 1'b1;
         end
         S_HEAD: begin
            mul_a = wide_type'(held_ff[RES_LEFT_ANG]) - wide_type'(held_ff[RES_RIGHT_ANG]);
            mul_b = mul_b_type'(rot_ff);
         end
         S_LIN: begin
            mul_a = wide_type'(held_ff[RES_LEFT_SPD]) + wide_type'(held_ff[RES_RIGHT_SPD]);
            mul_b = mul_b_type'(radius_ff);
         end
         S_TURN: begin
            mul_a = wide_type'(held_ff[RES_RIGHT_SPD]) - wide_type'(held_ff[RES_LEFT_SPD]);
            mul_b = mul_b_type'(rot_ff);
         end
         S_XC: begin
            mul_a = wide_type'(cordic_cos);
            mul_b = mul_b_type'(held_ff[RES_LINEAR]);
         end
         S_YC: begin
            mul_a = wide_type'(cordic_sin);
            mul_b = mul_b_type'(held_ff[RES_LINEAR]);
         end
         S_XP, S_YP: begin
            mul_a = t_ff;
            mul_b = mul_b_type'(period_ff);
         end
         S_TRAV: begin
            mul_a = wide_type'(held_ff[RES_LINEAR]);
            mul_b = mul_b_type'(period_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
      mul_ctrl.start = !go_ff && (state_ff >= S_ANG_L) && (state_ff <= S_TURN ||
         (state_ff >= S_XC && state_ff <= S_TRAV));
   end

   assign cordic_start = (state_ff == S_CORDIC) && !go_ff;

   always_comb begin
      state_in     = state_ff;
      go_in        = go_ff;
      enc_l_in     = enc_l_ff;
      enc_r_in     = enc_r_ff;
      pitch_in     = pitch_ff;
      prate_in     = prate_ff;
      unw_l_in     = unw_l_ff;
      unw_r_in     = unw_r_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      raw_l_in     = raw_l_ff;
      raw_r_in     = raw_r_ff;
      t_in         = t_ff;
      z_in         = z_ff;
      held_in      = held_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mod_r_in     = mod_r_ff;
      mod_d_in     = mod_d_ff;
      mod_cnt_in   = mod_cnt_ff;
      if (mul_ctrl.start || cordic_start) begin
         go_in = 1'b1;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_ch.payload.timed_out) begin
                  unw_l_in = '0;
                  unw_r_in = '0;
                  for (int i = 0; i < RES_COUNT; i++) begin
                     held_in[i] = '0;
                  end
                  state_in = S_DONE;
               end else if (req_ch.payload.measuring) begin
                  enc_l_in = req_ch.payload.left_enc_angle;
                  enc_r_in = req_ch.payload.right_enc_angle;
                  pitch_in = req_ch.payload.body_pitch;
                  prate_in = req_ch.payload.body_pitch_rate;
                  state_in = S_MOD_L;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_MOD_L, S_MOD_R, S_HMOD: begin
            if (!go_ff) begin
               go_in = 1'b1;
               if (state_ff == S_MOD_L) begin
                  mod_r_in = mod_type'(unw_l_ff) - mod_type'(enc_l_ff) + PI_FX + ENC_MOD_BASE;
                  mod_d_in = ENC_MOD_BASE;
                  mod_cnt_in = MOD_CNT_W'(ENC_MOD_SHIFT);
               end else if (state_ff == S_MOD_R) begin
                  mod_r_in = mod_type'(unw_r_ff) - mod_type'(enc_r_ff) + PI_FX + ENC_MOD_BASE;
                  mod_d_in = ENC_MOD_BASE;
                  mod_cnt_in = MOD_CNT_W'(ENC_MOD_SHIFT);
               end else begin
                  mod_r_in = (mod_type'(held_ff[RES_HEADING]) <<< HEAD_UP_SHIFT) + PI_Q30 +
                     HEAD_MOD_BASE;
                  mod_d_in = HEAD_MOD_BASE;
                  mod_cnt_in = MOD_CNT_W'(HEAD_MOD_SHIFT);
               end
            end else begin
               mod_r_in   = mod_next_r;
               mod_d_in   = mod_d_ff >>> 1;
               mod_cnt_in = mod_cnt_ff - MOD_CNT_W'(1);
               if (mod_cnt_ff == '0) begin
                  go_in = 1'b0;
                  if (state_ff == S_MOD_L) begin
                     dl_in    = delta_word;
                     unw_l_in = unw_l_ff + delta_word;
                     state_in = S_MOD_R;
                  end else if (state_ff == S_MOD_R) begin
                     dr_in    = delta_word;
                     unw_r_in = unw_r_ff + delta_word;
                     state_in = S_ANG_L;
                  end else begin
                     z_in     = head_z[ANG_W-1:0];
                     state_in = S_CORDIC;
                  end
               end
            end
         end
         S_CORDIC: begin
            if (go_ff && !cordic_busy) begin
               go_in    = 1'b0;
               state_in = S_XC;
            end
         end
         S_ANG_L: begin
            if (mul_done) begin
               held_in[RES_LEFT_ANG] = sat_word(wide_type'(pitch_ff) - prod_r16);
               go_in = 1'b0;
               state_in = S_ANG_R;
            end
         end
         S_ANG_R: begin
            if (mul_done) begin
               held_in[RES_RIGHT_ANG] = sat_word(wide_type'(pitch_ff) + prod_r16);
               go_in = 1'b0;
               state_in = S_RATE_L;
            end
         end
         S_RATE_L: begin
            if (mul_done) begin
               t_in = mul_product;
               go_in = 1'b0;
               state_in = S_RAW_L;
            end
         end
         S_RAW_L: begin
            if (mul_done) begin
               raw_l_in = sat_word(wide_type'(prate_ff) - prod_r16);
               go_in = 1'b0;
               state_in = S_RATE_R;
            end
         end
         S_RATE_R: begin
            if (mul_done) begin
               t_in = mul_product;
               go_in = 1'b0;
               state_in = S_RAW_R;
            end
         end
         S_RAW_R: begin
            if (mul_done) begin
               raw_r_in = sat_word(wide_type'(prate_ff) + prod_r16);
               go_in = 1'b0;
               state_in = S_FILT_L0;
            end
         end
         S_FILT_L0: begin
            if (mul_done) begin
               go_in = 1'b0;
               state_in = S_FILT_L1;
            end
         end
         S_FILT_L1: begin
            if (mul_done) begin
               held_in[RES_LEFT_SPD] = sat_word(prod_r16);
               go_in = 1'b0;
               state_in = S_FILT_R0;
            end
         end
         S_FILT_R0: begin
            if (mul_done) begin
               go_in = 1'b0;
               state_in = S_FILT_R1;
            end
         end
         S_FILT_R1: begin
            if (mul_done) begin
               held_in[RES_RIGHT_SPD] = sat_word(prod_r16);
               go_in = 1'b0;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (mul_done) begin
               held_in[RES_HEADING] = sat_word(prod_r16);
               go_in = 1'b0;
               state_in = S_LIN;
            end
         end
         S_LIN: begin
            if (mul_done) begin
               held_in[RES_LINEAR] = sat_word(prod_r17);
               go_in = 1'b0;
               state_in = S_TURN;
            end
         end
         S_TURN: begin
            if (mul_done) begin
               held_in[RES_TURN] = sat_word(prod_r16);
               go_in = 1'b0;
               state_in = S_HMOD;
            end
         end
         S_XC: begin
            if (mul_done) begin
               t_in = prod_r30;
               go_in = 1'b0;
               state_in = S_XP;
            end
         end
         S_XP: begin
            if (mul_done) begin
               held_in[RES_POS_X] = held_ff[RES_POS_X] + prod_r16[31:0];
               go_in = 1'b0;
               state_in = S_YC;
            end
         end
         S_YC: begin
            if (mul_done) begin
               t_in = prod_r30;
               go_in = 1'b0;
               state_in = S_YP;
            end
         end
         S_YP: begin
            if (mul_done) begin
               held_in[RES_POS_Y] = held_ff[RES_POS_Y] + prod_r16[31:0];
               go_in = 1'b0;
               state_in = S_TRAV;
            end
         end
         S_TRAV: begin
            if (mul_done) begin
               held_in[RES_TRAVELLED] = held_ff[RES_TRAVELLED] + prod_r16[31:0];
               go_in = 1'b0;
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            held_in[RES_MEAN_ANG] = sat_word(round_shift(wide_type'(held_ff[RES_LEFT_ANG]) +
               wide_type'(held_ff[RES_RIGHT_ANG]), 1));
            held_in[RES_MEAN_SPD] = sat_word(round_shift(wide_type'(held_ff[RES_LEFT_SPD]) +
               wide_type'(held_ff[RES_RIGHT_SPD]), 1));
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_in.left_wheel_angle  = held_ff[RES_LEFT_ANG];
               out_in.right_wheel_angle = held_ff[RES_RIGHT_ANG];
               out_in.mean_wheel_angle  = held_ff[RES_MEAN_ANG];
               out_in.left_wheel_speed  = held_ff[RES_LEFT_SPD];
               out_in.right_wheel_speed = held_ff[RES_RIGHT_SPD];
               out_in.mean_wheel_speed  = held_ff[RES_MEAN_SPD];
               out_in.heading           = held_ff[RES_HEADING];
               out_in.linear_speed      = held_ff[RES_LINEAR];
               out_in.turn_rate         = held_ff[RES_TURN];
               out_in.position_x        = held_ff[RES_POS_X];
               out_in.position_y        = held_ff[RES_POS_Y];
               out_in.travelled         = held_ff[RES_TRAVELLED];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unw_l_ff     <= '0;
         unw_r_ff     <= '0;
         for (int i = 0; i < RES_COUNT; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         unw_l_ff     <= unw_l_in;
         unw_r_ff     <= unw_r_in;
         held_ff      <= held_in;
      end
      enc_l_ff   <= enc_l_in;
      enc_r_ff   <= enc_r_in;
      pitch_ff   <= pitch_in;
      prate_ff   <= prate_in;
      dl_ff      <= dl_in;
      dr_ff      <= dr_in;
      raw_l_ff   <= raw_l_in;
      raw_r_ff   <= raw_r_in;
      t_ff       <= t_in;
      z_ff       <= z_in;
      out_ff     <= out_in;
      mod_r_ff   <= mod_r_in;
      mod_d_ff   <= mod_d_in;
      mod_cnt_ff <= mod_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 16'd164;
         rate_ff   <= 16'd400;
         alpha_ff  <= 17'd3121;
         radius_ff <= 16'd8192;
         rot_ff    <= 17'd14895;
         igr_ff    <= 16'd20316;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            REG_SAMPLE_PERIOD:     period_ff <= pwdata[15:0];
            REG_SAMPLE_RATE_HZ:    rate_ff   <= pwdata[15:0];
            REG_FILTER_ALPHA:      alpha_ff  <= pwdata[16:0];
            REG_WHEEL_RADIUS:      radius_ff <= pwdata[15:0];
            REG_RADIUS_OVER_TRACK: rot_ff    <= pwdata[16:0];
            REG_INV_GEAR_RATIO:    igr_ff    <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_SAMPLE_PERIOD:     prdata = 32'(period_ff);
         REG_SAMPLE_RATE_HZ:    prdata = 32'(rate_ff);
         REG_FILTER_ALPHA:      prdata = 32'(alpha_ff);
         REG_WHEEL_RADIUS:      prdata = 32'(radius_ff);
         REG_RADIUS_OVER_TRACK: prdata = 32'(rot_ff);
         REG_INV_GEAR_RATIO:    prdata = 32'(igr_ff);
         default:               prdata = '0;
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted request left the sequencer idle");

   a_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.payload.timed_out) |=>
         (unw_l_ff == '0 && unw_r_ff == '0 && held_ff[RES_POS_X] == '0 &&
          held_ff[RES_LEFT_SPD] == '0))
      else $error("timeout did not clear the odometry state");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready)) |=>
         (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished result was not moved to the output register");

   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_ctrl.start |-> !mul_busy)
      else $error("multiplier started while still busy");

endmodule
